// ===== hw/rtl/irtd_pkg.sv =====
package irtd_pkg;

	// Every reading, average and threshold is a 12-bit unsigned quantity.
	localparam int FIELD_W = 12;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam int CFG_ADDR_W = 1;

	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_RIGHT = 2'd2
	} dir_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MIN_LEVEL = 1'b0,
		REG_TOLERANCE = 1'b1
	} cfg_reg_t;

	// Control of one window accumulator. en moves the whole pipeline, rd marks an
	// item entering the read-modify-write stage, wr marks the item in that stage
	// as one that updates the window.
	typedef struct packed {
		logic en;
		logic rd;
		logic wr;
	} win_ctl_t;

endpackage

// ===== hw/rtl/ir_pair_turn_detector_top.sv =====
// Infrared pair turn detector.
// Input channel s_*: one transfer carries one front/back converter reading pair.
// Output channel m_*: one transfer per input transfer, in the same order, with
// the turn direction, the windowed error average and both window averages.
// Configuration: cfg_we writes cfg_wdata to the register picked by cfg_addr
// (0 minimum level, 1 tolerance); write only while no item is in flight.
// A result reaches m_tvalid through the stage registers and the output
// register. Throughput: one item per cycle while the skid register is free,
// set by one read-modify-write pass of each window memory per item (read on
// entering stage 2, updated and written back from it, forwarded to neighbours).
// Stalls: the output register is backed by one skid register, so an item is
// still taken while a result waits; s_tready falls only once the skid register
// is full, and then the whole pipeline holds until m_tready is seen.
// Reset: arst_n clears the valid and configuration registers, running totals
// and window positions, but not the window memories; a slot not yet written
// since reset counts as zero, so the block is ready straight after reset.
module ir_pair_turn_detector_top #(
	parameter int WINDOW_DEPTH       = 8,
	parameter int ERROR_WINDOW_DEPTH = 8,
	parameter int SAMPLE_DIVIDER     = 1,
	parameter int SAMPLE_BITS        = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// front_sample [11:0], back_sample [23:12]
	input  logic [irtd_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// direction [1:0], error_average [13:2], front_average [25:14],
	// back_average [37:26], zero [39:38]
	output logic [irtd_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [irtd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [irtd_pkg::FIELD_W-1:0]        cfg_wdata
);

	import irtd_pkg::*;

	localparam int KEEP = SAMPLE_BITS < FIELD_W ? SAMPLE_BITS : FIELD_W;
	localparam int TW   = FIELD_W + $clog2(WINDOW_DEPTH);
	localparam int ETW  = FIELD_W + $clog2(ERROR_WINDOW_DEPTH);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [FIELD_W-1:0] min_level_q, tolerance_q;

	logic [FIELD_W-1:0] smp_f_s1, smp_b_s1;
	logic [FIELD_W-1:0] div_f, div_b;
	logic [2*TW-1:0]    win_total;
	logic [TW-1:0]      tot_f_s3, tot_b_s3;
	logic [FIELD_W-1:0] fa, ba;

	logic               above_min, right, left;
	logic [FIELD_W-1:0] diff;
	dir_t               dir_s4;

	dir_t               dir_s5, dir_s6, dir_s7;
	logic               push_s5;
	logic [FIELD_W-1:0] diff_s5;
	logic [FIELD_W-1:0] fa_s5, ba_s5, fa_s6, ba_s6, fa_s7, ba_s7;
	logic [ETW-1:0]     err_total, etot_s6;
	logic [FIELD_W-1:0] err_avg, err_field;

	logic [OUT_DATA_W-1:0] result;
	logic                  out_v_q, skid_v_q;
	logic [OUT_DATA_W-1:0] out_data_q, skid_data_q;

	win_ctl_t sens_ctl, err_ctl;

	// The pipeline moves as one while the skid register is free.
	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= '0;
			tolerance_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_MIN_LEVEL: min_level_q <= cfg_wdata;
				REG_TOLERANCE: tolerance_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1 keeps only the converter bits; stage 2 sees the divided readings.
	irtd_cdiv #(
		.DIVIDEND_W(FIELD_W),
		.DIVISOR   (SAMPLE_DIVIDER),
		.QUOT_W    (FIELD_W)
	) u_div_f (
		.clk     (clk),
		.en      (adv),
		.dividend(smp_f_s1),
		.quotient(div_f)
	);

	irtd_cdiv #(
		.DIVIDEND_W(FIELD_W),
		.DIVISOR   (SAMPLE_DIVIDER),
		.QUOT_W    (FIELD_W)
	) u_div_b (
		.clk     (clk),
		.en      (adv),
		.dividend(smp_b_s1),
		.quotient(div_b)
	);

	// Front and back windows share one memory; the slot is read as the item
	// enters stage 2 and written back from stage 2.
	assign sens_ctl = '{en: adv, rd: v_s1, wr: v_s2};

	irtd_win #(
		.DEPTH(WINDOW_DEPTH),
		.LANES(2)
	) u_sens_win (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sens_ctl),
		.wr_data({div_b, div_f}),
		.total  (win_total)
	);

	// Stage 3 holds the new totals; stage 4 sees the averages.
	irtd_cdiv #(
		.DIVIDEND_W(TW),
		.DIVISOR   (WINDOW_DEPTH),
		.QUOT_W    (FIELD_W)
	) u_div_fa (
		.clk     (clk),
		.en      (adv),
		.dividend(tot_f_s3),
		.quotient(fa)
	);

	irtd_cdiv #(
		.DIVIDEND_W(TW),
		.DIVISOR   (WINDOW_DEPTH),
		.QUOT_W    (FIELD_W)
	) u_div_ba (
		.clk     (clk),
		.en      (adv),
		.dividend(tot_b_s3),
		.quotient(ba)
	);

	// Turn decision: both averages must reach the minimum level and differ by
	// more than the tolerance.
	always_comb begin
		above_min = (fa >= min_level_q) && (ba >= min_level_q);
		diff      = (fa > ba) ? (fa - ba) : (ba - fa);
		right     = above_min && (fa > ba) && (diff > tolerance_q);
		left      = above_min && (ba > fa) && (diff > tolerance_q);
		if (right) begin
			dir_s4 = DIR_RIGHT;
		end else if (left) begin
			dir_s4 = DIR_LEFT;
		end else begin
			dir_s4 = DIR_NONE;
		end
	end

	// Only turning items take part in the error window.
	assign err_ctl = '{en: adv, rd: v_s4 && (right || left), wr: v_s5 && push_s5};

	irtd_win #(
		.DEPTH(ERROR_WINDOW_DEPTH),
		.LANES(1)
	) u_err_win (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (err_ctl),
		.wr_data(diff_s5),
		.total  (err_total)
	);

	irtd_cdiv #(
		.DIVIDEND_W(ETW),
		.DIVISOR   (ERROR_WINDOW_DEPTH),
		.QUOT_W    (FIELD_W)
	) u_div_err (
		.clk     (clk),
		.en      (adv),
		.dividend(etot_s6),
		.quotient(err_avg)
	);

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			smp_f_s1 <= FIELD_W'(s_tdata[KEEP-1:0]);
			smp_b_s1 <= FIELD_W'(s_tdata[FIELD_W +: KEEP]);
			tot_f_s3 <= win_total[0 +: TW];
			tot_b_s3 <= win_total[TW +: TW];
			dir_s5   <= dir_s4;
			push_s5  <= right || left;
			diff_s5  <= diff;
			fa_s5    <= fa;
			ba_s5    <= ba;
			dir_s6   <= dir_s5;
			fa_s6    <= fa_s5;
			ba_s6    <= ba_s5;
			etot_s6  <= err_total;
			dir_s7   <= dir_s6;
			fa_s7    <= fa_s6;
			ba_s7    <= ba_s6;
		end
	end

	assign err_field = (dir_s7 == DIR_NONE) ? '0 : err_avg;
	assign result    = {2'b00, ba_s7, fa_s7, err_field, dir_s7};

	// Output register with one skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s7) begin
			if (out_v_q && !m_tready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) begin
				out_data_q <= skid_data_q;
			end
		end else if (v_s7) begin
			if (out_v_q && !m_tready) begin
				skid_data_q <= result;
			end else begin
				out_data_q <= result;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hw/rtl/irtd_ram.sv =====
module irtd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/irtd_cdiv.sv =====
module irtd_cdiv #(
	parameter int DIVIDEND_W = 12,
	parameter int DIVISOR    = 1,
	parameter int QUOT_W     = 12
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DIVIDEND_W-1:0] dividend,
	output logic [QUOT_W-1:0]     quotient
);

	// Division by a constant as a multiplication by a rounded-up reciprocal.
	// With the shift at dividend width plus ceil(log2 divisor) the result is
	// exact over the full dividend range.
	localparam int SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
	localparam int MULT_W = DIVIDEND_W + 1;
	localparam int PROD_W = DIVIDEND_W + MULT_W;
	localparam logic [63:0] MULT64 =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MULT_W-1:0] MULT = MULT64[MULT_W-1:0];

	logic [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(dividend) * PROD_W'(MULT);
		end
	end

	assign quotient = QUOT_W'(prod_s1 >> SHIFT);

endmodule

// ===== hw/rtl/irtd_win.sv =====
module irtd_win #(
	parameter int DEPTH = 8,
	parameter int LANES = 2
) (
	input  logic                                                        clk,
	input  logic                                                        arst_n,
	input  irtd_pkg::win_ctl_t                                          ctl,
	input  logic [LANES*irtd_pkg::FIELD_W-1:0]                          wr_data,
	output logic [LANES*(irtd_pkg::FIELD_W+$clog2(DEPTH))-1:0]          total
);

	import irtd_pkg::*;

	localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int TW     = FIELD_W + $clog2(DEPTH);
	localparam int DATA_W = LANES * FIELD_W;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0]     pos_q;
	logic              wrapped_q;
	logic [AW-1:0]     slot_s1;
	logic              oldv_s1;
	logic              fwd_v_q;
	logic [DATA_W-1:0] fwd_data_q;
	logic [TW-1:0]     tot_q [LANES];
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] old_data;

	irtd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.en && ctl.wr),
		.waddr(slot_s1),
		.wdata(wr_data),
		.re   (ctl.en),
		.raddr(pos_q),
		.rdata(rdata)
	);

	// Slots fill in order from zero, so until the first wrap the slot being
	// replaced has never been written and counts as zero.
	always_comb begin
		if (!oldv_s1) begin
			old_data = '0;
		end else if (fwd_v_q) begin
			old_data = fwd_data_q;
		end else begin
			old_data = rdata;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			total[l*TW +: TW] = tot_q[l] - TW'(old_data[l*FIELD_W +: FIELD_W])
				+ TW'(wr_data[l*FIELD_W +: FIELD_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			oldv_s1   <= 1'b0;
			fwd_v_q   <= 1'b0;
			for (int l = 0; l < LANES; l++) begin
				tot_q[l] <= '0;
			end
		end else if (ctl.en) begin
			if (ctl.rd) begin
				oldv_s1 <= wrapped_q;
				if (pos_q == LAST) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			// A write in the same cycle as a read of that slot is not seen by the
			// memory output, so it is carried forward.
			fwd_v_q <= ctl.wr && (slot_s1 == pos_q);
			if (ctl.wr) begin
				for (int l = 0; l < LANES; l++) begin
					tot_q[l] <= total[l*TW +: TW];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			fwd_data_q <= wr_data;
			if (ctl.rd) begin
				slot_s1 <= pos_q;
			end
		end
	end

endmodule

// ===== hw/rtl/irtd_checker.sv =====
module irtd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	import irtd_pkg::*;

	// A result held back by the receiver stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// No turn means no error average.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == DIR_NONE) |-> (m_tdata[13:2] == 12'd0))
		else $error("error average set without a turn");

	// The input side only stalls behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_stall_start: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stall began without an output stall");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result shown during reset");

endmodule

bind ir_pair_turn_detector_top irtd_checker u_irtd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import irtd_pkg::*;

	localparam int WIN_DEPTH      = 8;
	localparam int ERR_DEPTH      = 8;
	localparam int SAMPLE_DIVIDER = 1;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SINK_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 30;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [FIELD_W-1:0]    cfg_wdata;

	// Knobs that the main sequence turns per phase to shape the traffic.
	bit sender_steady;
	bit sink_steady;
	bit sink_hold_req;
	int cycle_count;

	// One output transfer, split into its fields.
	typedef struct {
		dir_t             direction;
		logic [FIELD_W-1:0] error_average;
		logic [FIELD_W-1:0] front_average;
		logic [FIELD_W-1:0] back_average;
	} turn_t;

	// The scoreboard keeps its own copy of the three sliding windows and of the
	// two thresholds. Every accepted reading pair produces exactly one expected
	// turn report, and reports are checked strictly in order.
	class turn_scoreboard;
		logic [FIELD_W-1:0] front_hist[WIN_DEPTH];
		logic [FIELD_W-1:0] back_hist[WIN_DEPTH];
		logic [FIELD_W-1:0] diff_hist[ERR_DEPTH];
		logic [14:0]        front_sum;
		logic [14:0]        back_sum;
		logic [14:0]        diff_sum;
		int                 win_slot;
		int                 diff_slot;
		logic [FIELD_W-1:0] min_level;
		logic [FIELD_W-1:0] tolerance;
		turn_t              expected_turns[$];
		int                 failures;

		function new();
			foreach (front_hist[i]) begin
				front_hist[i] = '0;
				back_hist[i] = '0;
			end
			foreach (diff_hist[i])
				diff_hist[i] = '0;
			front_sum = '0;
			back_sum = '0;
			diff_sum = '0;
			win_slot = 0;
			diff_slot = 0;
			min_level = '0;
			tolerance = '0;
			failures = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [FIELD_W-1:0] value);
			case (idx)
				REG_MIN_LEVEL: min_level = value;
				REG_TOLERANCE: tolerance = value;
				default: ;
			endcase
		endfunction

		function void flag(string field, int unsigned exp_val, int unsigned got_val);
			failures++;
			$error("%s: expected %0d, got %0d", field, exp_val, got_val);
		endfunction

		// Pushes one difference into the error window and returns its new average.
		function logic [FIELD_W-1:0] push_diff(logic [FIELD_W-1:0] diff);
			diff_sum = diff_sum - 15'(diff_hist[diff_slot]) + 15'(diff);
			diff_hist[diff_slot] = diff;
			diff_slot = (diff_slot == ERR_DEPTH - 1) ? 0 : diff_slot + 1;
			return FIELD_W'(diff_sum / ERR_DEPTH);
		endfunction

		function void note_pair(logic [FIELD_W-1:0] front, logic [FIELD_W-1:0] back);
			logic [FIELD_W-1:0] f;
			logic [FIELD_W-1:0] b;
			turn_t t;
			f = FIELD_W'(front / SAMPLE_DIVIDER);
			b = FIELD_W'(back / SAMPLE_DIVIDER);
			front_sum = front_sum - 15'(front_hist[win_slot]) + 15'(f);
			back_sum = back_sum - 15'(back_hist[win_slot]) + 15'(b);
			front_hist[win_slot] = f;
			back_hist[win_slot] = b;
			win_slot = (win_slot == WIN_DEPTH - 1) ? 0 : win_slot + 1;
			t.front_average = FIELD_W'(front_sum / WIN_DEPTH);
			t.back_average = FIELD_W'(back_sum / WIN_DEPTH);
			t.direction = DIR_NONE;
			t.error_average = '0;
			// A weak reading on either side, or a difference within tolerance,
			// reports no turn and leaves the error window alone.
			if (t.front_average >= min_level && t.back_average >= min_level) begin
				if (t.front_average > t.back_average &&
						t.front_average - t.back_average > tolerance) begin
					t.direction = DIR_RIGHT;
					t.error_average = push_diff(t.front_average - t.back_average);
				end else if (t.back_average > t.front_average &&
						t.back_average - t.front_average > tolerance) begin
					t.direction = DIR_LEFT;
					t.error_average = push_diff(t.back_average - t.front_average);
				end
			end
			expected_turns.push_back(t);
		endfunction

		function void check_turn(logic [OUT_DATA_W-1:0] data);
			turn_t t;
			if (expected_turns.size() == 0) begin
				failures++;
				$error("result with no expectation waiting: %h", data);
				return;
			end
			t = expected_turns.pop_front();
			if (data[1:0] !== t.direction)
				flag("direction", t.direction, data[1:0]);
			if (data[13:2] !== t.error_average)
				flag("error_average", t.error_average, data[13:2]);
			if (data[25:14] !== t.front_average)
				flag("front_average", t.front_average, data[25:14]);
			if (data[37:26] !== t.back_average)
				flag("back_average", t.back_average, data[37:26]);
		endfunction

		function int pending();
			return expected_turns.size();
		endfunction
	endclass

	turn_scoreboard sb = new();

	ir_pair_turn_detector_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// A reading scattered around a level, clipped to the converter range.
	function automatic logic [FIELD_W-1:0] near_level(int level);
		int v;
		v = level + $urandom_range(0, 120) - 60;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[FIELD_W-1:0];
	endfunction

	// Offers one reading pair and returns once it has been taken. The pair is
	// noted only at the edge where both tvalid and tready were high. If the
	// next transfer follows straight on, tvalid is simply left high.
	task automatic send_pair(input logic [FIELD_W-1:0] front, input logic [FIELD_W-1:0] back);
		int gap;
		s_tdata <= {back, front};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_pair(front, back);
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= IN_DATA_W'($urandom_range(0, (1 << IN_DATA_W) - 1));
			repeat (gap)
				@(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected report has come back. The
	// extra edge first keeps the lowering of tvalid apart from the next raise.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	// Both thresholds are written one after the other; the write enable
	// stays high across them so it is only assigned once per edge.
	task automatic write_thresholds(input logic [FIELD_W-1:0] level,
			input logic [FIELD_W-1:0] tol);
		cfg_we <= 1'b1;
		cfg_addr <= REG_MIN_LEVEL;
		cfg_wdata <= level;
		@(posedge clk);
		sb.set_register(REG_MIN_LEVEL, level);
		cfg_addr <= REG_TOLERANCE;
		cfg_wdata <= tol;
		@(posedge clk);
		sb.set_register(REG_TOLERANCE, tol);
		cfg_we <= 1'b0;
	endtask

	// Random traffic. Most pairs sit around two slowly moving levels so that
	// the averages stay apart long enough to fill the error window with real
	// turns; the rest is uniform noise, rail values and balanced pairs.
	task automatic random_pairs(input int count);
		int front_level;
		int back_level;
		int kind;
		logic [FIELD_W-1:0] f;
		logic [FIELD_W-1:0] b;
		front_level = 0;
		back_level = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				front_level = $urandom_range(0, 4095);
				back_level = $urandom_range(0, 4095);
			end
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				f = near_level(front_level);
				b = near_level(back_level);
			end else if (kind < 80) begin
				f = FIELD_W'($urandom_range(0, 4095));
				b = FIELD_W'($urandom_range(0, 4095));
			end else if (kind < 90) begin
				f = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
				b = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			end else begin
				f = near_level(front_level);
				b = f;
			end
			send_pair(f, b);
		end
	endtask

	// Checks every output transfer, using the values seen just before the edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_turn(m_tdata);
	end

	// Receiver pacing. A hold request from the main sequence makes it refuse
	// results for a long stretch, so that the pipeline and its skid register
	// fill up and the input side is pushed back.
	initial begin : sink_pacing
		int run;
		int gap;
		forever begin
			if (sink_hold_req) begin
				m_tready <= 1'b0;
				repeat (SINK_HOLD)
					@(posedge clk);
				sink_hold_req = 1'b0;
			end else if (sink_steady) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 16);
				m_tready <= 1'b1;
				repeat (run)
					@(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap)
						@(posedge clk);
				end
			end
		end
	end

	// Run-time guard: a hang anywhere ends the run as a failure.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ir_pair_turn_detector_top verification failed");
		$finish;
	end

	initial begin : main_sequence
		logic [FIELD_W-1:0] level;
		logic [FIELD_W-1:0] tol;
		int count;
		sender_steady = 1'b0;
		sink_steady = 1'b0;
		sink_hold_req = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_MIN_LEVEL;
		cfg_wdata <= '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, open thresholds: balanced zeros, a full-scale step on
		// each side, then full scale on both until the averages are equal, and
		// a one-count imbalance that must already count as a turn.
		write_thresholds(12'd0, 12'd0);
		send_pair(12'd0, 12'd0);
		send_pair(12'hFFF, 12'd0);
		send_pair(12'd0, 12'hFFF);
		repeat (8)
			send_pair(12'hFFF, 12'hFFF);
		send_pair(12'hFFF, 12'hFFE);
		drain();

		// Directed part, tight thresholds: a difference inside the tolerance,
		// turns both ways, then zeros until the averages fall below the
		// minimum level and the signal counts as weak.
		write_thresholds(12'd2048, 12'd100);
		repeat (2)
			send_pair(12'hFFF, 12'hFFF);
		repeat (2)
			send_pair(12'hFFF, 12'd3000);
		repeat (3)
			send_pair(12'd3000, 12'hFFF);
		repeat (5)
			send_pair(12'd0, 12'd0);
		drain();

		// Random phases: first the four corners of the threshold space, then
		// random thresholds. One phase runs with no idling at all, one has the
		// receiver hold off while the sender keeps pushing, and one pauses the
		// sender halfway until everything has come back.
		for (int p = 0; p < 12; p++) begin
			case (p)
				0: begin level = 12'd0; tol = 12'd0; end
				1: begin level = 12'hFFF; tol = 12'hFFF; end
				2: begin level = 12'd0; tol = 12'hFFF; end
				3: begin level = 12'hFFF; tol = 12'd0; end
				default: begin
					level = FIELD_W'($urandom_range(0, 2500));
					tol = FIELD_W'($urandom_range(0, 800));
				end
			endcase
			count = (p < 4) ? 50 : 130;
			write_thresholds(level, tol);
			sender_steady = (p == 6 || p == 8);
			sink_steady = (p == 6 || p == 7);
			if (p == 8)
				sink_hold_req = 1'b1;
			if (p == 9) begin
				random_pairs(count / 2);
				drain();
				random_pairs(count - count / 2);
			end else begin
				random_pairs(count);
			end
			drain();
		end

		sender_steady = 1'b0;
		sink_steady = 1'b0;
		// Give any stray result time to show up before the verdict.
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (sb.pending() > 0) begin
			sb.failures++;
			$error("%0d expected results never arrived", sb.pending());
		end
		if (sb.failures == 0)
			$display("ir_pair_turn_detector_top verification clean");
		else
			$display("ir_pair_turn_detector_top verification failed");
		$finish;
	end

endmodule
